### hdl/bdq_pkg.sv
// types and codes shared by the bounded deque block and its channel interfaces
// no dependencies
package bdq_pkg;

	typedef logic [2:0]         func_t;
	typedef logic [7:0]         pos_t;
	typedef logic signed [31:0] word_t;
	typedef logic [1:0]         status_t;
	typedef logic [8:0]         count_t;

	localparam func_t FN_PUSH_TAIL = 3'd0;
	localparam func_t FN_PUSH_HEAD = 3'd1;
	localparam func_t FN_POP_TAIL  = 3'd2;
	localparam func_t FN_POP_HEAD  = 3'd3;
	localparam func_t FN_READ      = 3'd4;
	localparam func_t FN_WRITE     = 3'd5;
	localparam func_t FN_SORT      = 3'd6;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_EMPTY  = 2'd2;
	localparam status_t ST_BOUNDS = 2'd3;

	typedef struct packed {
		func_t func;
		pos_t  position;
		word_t value;
	} req_item_t;

endpackage

### hdl/bdq_req_if.sv
// request channel of the bounded deque: valid/ready plus operation payload
// depends on bdq_pkg
interface bdq_req_if import bdq_pkg::*; ();
	logic  valid;
	logic  ready;
	func_t func;
	pos_t  position;
	word_t value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink (input valid, input func, input position, input value, output ready);
endinterface

### hdl/bdq_rsp_if.sv
// response channel of the bounded deque: valid/ready plus result payload
// depends on bdq_pkg
interface bdq_rsp_if import bdq_pkg::*; ();
	logic    valid;
	logic    ready;
	word_t   data;
	status_t status;
	count_t  count;

	modport source (output valid, output data, output status, output count, input ready);
	modport sink (input valid, input data, input status, input count, output ready);
endinterface

### hdl/bounded_deque_with_sort.sv
// bounded double-ended queue of signed words with in-place insertion sort
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if
// push, write, full/empty/bounds errors and no-op stage their result from the exec state, pop
// and read after a registered store read; sort loads each key, shifts larger words up one place
// and then places it; results wait while the response register is held; one transaction in
// flight, next accepted once the result is staged; one store write port and one read port
// reset clears count, front pointer and control; store contents stay undefined, no clearing pass
module bounded_deque_with_sort
	import bdq_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 8) ? CW : 8;
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_W  = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_W  = CW'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RDATA,
		S_LOAD,
		S_CMP,
		S_PLACE,
		S_DONE
	} state_t;

	state_t        state_q, state_d;
	req_item_t     item_q, item_d;
	logic [CW-1:0] held_q, held_d;
	logic [AW-1:0] front_q, front_d;
	logic [AW-1:0] i_q, i_d;
	logic [AW-1:0] j_q, j_d;
	word_t         key_q, key_d;

	logic    rsp_valid_q;
	word_t   rsp_data_q;
	status_t rsp_status_q;
	count_t  rsp_count_q;

	word_t         mem_q [DEPTH];
	word_t         rdata_q;
	logic          mem_we, wr_direct, rd_en;
	logic [AW-1:0] wr_log, rd_log, wr_phys, rd_phys;
	word_t         wr_data;

	logic          emit;
	word_t         emit_data;
	status_t       emit_status;
	logic          out_free, full, empty, oob;
	logic [AW-1:0] front_dec, front_inc;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] fr, input logic [AW-1:0] lg);
		logic [AW:0] sum;
		sum = {1'b0, fr} + {1'b0, lg};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign full      = (held_q == FULL_W);
	assign empty     = (held_q == '0);
	assign oob       = CMPW'(item_q.position) >= CMPW'(held_q);
	assign front_dec = (front_q == '0) ? LAST_W : front_q - 1'b1;
	assign front_inc = (front_q == LAST_W) ? '0 : front_q + 1'b1;
	assign wr_phys   = wr_direct ? front_dec : slot_of(front_q, wr_log);
	assign rd_phys   = slot_of(front_q, rd_log);

	always_comb begin
		state_d     = state_q;
		item_d      = item_q;
		held_d      = held_q;
		front_d     = front_q;
		i_d         = i_q;
		j_d         = j_q;
		key_d       = key_q;
		mem_we      = 1'b0;
		wr_direct   = 1'b0;
		wr_log      = '0;
		wr_data     = item_q.value;
		rd_en       = 1'b0;
		rd_log      = '0;
		emit        = 1'b0;
		emit_data   = '0;
		emit_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					item_d.func     = req.func;
					item_d.position = req.position;
					item_d.value    = req.value;
					state_d         = S_EXEC;
				end
			end
			S_EXEC: begin
				case (item_q.func)
					FN_PUSH_TAIL: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (full) begin
								emit_status = ST_FULL;
							end else begin
								mem_we = 1'b1;
								wr_log = AW'(held_q);
								held_d = held_q + 1'b1;
							end
						end
					end
					FN_PUSH_HEAD: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (full) begin
								emit_status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								wr_direct = 1'b1;
								front_d   = front_dec;
								held_d    = held_q + 1'b1;
							end
						end
					end
					FN_POP_TAIL, FN_POP_HEAD: begin
						if (empty) begin
							if (out_free) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
								state_d     = S_IDLE;
							end
						end else begin
							rd_en   = 1'b1;
							rd_log  = (item_q.func == FN_POP_TAIL) ? AW'(held_q - 1'b1) : '0;
							state_d = S_RDATA;
						end
					end
					FN_READ: begin
						if (oob) begin
							if (out_free) begin
								emit        = 1'b1;
								emit_status = ST_BOUNDS;
								state_d     = S_IDLE;
							end
						end else begin
							rd_en   = 1'b1;
							rd_log  = AW'(item_q.position);
							state_d = S_RDATA;
						end
					end
					FN_WRITE: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = S_IDLE;
							if (oob) begin
								emit_status = ST_BOUNDS;
							end else begin
								mem_we = 1'b1;
								wr_log = AW'(item_q.position);
							end
						end
					end
					FN_SORT: begin
						if (held_q < CW'(2)) begin
							if (out_free) begin
								emit    = 1'b1;
								state_d = S_IDLE;
							end
						end else begin
							rd_en   = 1'b1;
							rd_log  = AW'(1);
							i_d     = AW'(1);
							state_d = S_LOAD;
						end
					end
					default: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_RDATA: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_data = rdata_q;
					state_d   = S_IDLE;
					if (item_q.func == FN_POP_TAIL) begin
						held_d = held_q - 1'b1;
					end else if (item_q.func == FN_POP_HEAD) begin
						held_d  = held_q - 1'b1;
						front_d = front_inc;
					end
				end
			end
			S_LOAD: begin
				key_d   = rdata_q;
				j_d     = i_q;
				rd_en   = 1'b1;
				rd_log  = i_q - 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (rdata_q > key_q) begin
					mem_we  = 1'b1;
					wr_log  = j_q;
					wr_data = rdata_q;
					j_d     = j_q - 1'b1;
					if (j_q == AW'(1)) begin
						state_d = S_PLACE;
					end else begin
						rd_en  = 1'b1;
						rd_log = j_q - AW'(2);
					end
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				mem_we  = 1'b1;
				wr_log  = j_q;
				wr_data = key_q;
				if ({1'b0, i_q} + 1'b1 == (AW + 1)'(held_q)) begin
					state_d = S_DONE;
				end else begin
					i_d     = i_q + 1'b1;
					rd_en   = 1'b1;
					rd_log  = i_q + 1'b1;
					state_d = S_LOAD;
				end
			end
			S_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			item_q       <= '0;
			held_q       <= '0;
			front_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			key_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_data_q   <= '0;
			rsp_status_q <= ST_OK;
			rsp_count_q  <= '0;
		end else begin
			state_q <= state_d;
			item_q  <= item_d;
			held_q  <= held_d;
			front_q <= front_d;
			i_q     <= i_d;
			j_q     <= j_d;
			key_q   <= key_d;
			if (emit) begin
				rsp_valid_q  <= 1'b1;
				rsp_data_q   <= emit_data;
				rsp_status_q <= emit_status;
				rsp_count_q  <= count_t'(held_d);
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_phys] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[rd_phys];
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.status = rsp_status_q;
	assign rsp.count  = rsp_count_q;

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.count == count_t'(DEPTH))
		else $error("full status with count below depth");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EMPTY |-> rsp.count == '0 && rsp.data == '0)
		else $error("empty status with nonzero count or data");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second transaction accepted while one is in progress");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL_W && front_q <= LAST_W)
		else $error("count or front pointer out of range");

	a_sort_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> j_q != '0 && j_q <= i_q && CW'(i_q) < held_q)
		else $error("sort compare index out of range");

endmodule

### dv/bounded_deque_with_sort_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for bounded_deque_with_sort: a clocked driver and monitor
// on the valid/ready channels, checked against an in-bench deque and sort predictor
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if and the bounded_deque_with_sort rtl
module bounded_deque_with_sort_tb;
	import bdq_pkg::*;

	localparam int    DQ_DEPTH = 256;
	localparam func_t FN_NOP   = 3'd7;

	typedef struct packed {
		word_t   data;
		status_t status;
		count_t  count;
	} deque_rsp_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic  drv_valid    = 1'b0;
	func_t drv_func     = FN_PUSH_TAIL;
	pos_t  drv_position = '0;
	word_t drv_value    = '0;
	logic  rcv_ready    = 1'b0;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	assign req_ch.valid    = drv_valid;
	assign req_ch.func     = drv_func;
	assign req_ch.position = drv_position;
	assign req_ch.value    = drv_value;
	assign rsp_ch.ready    = rcv_ready;

	bounded_deque_with_sort #(
		.DEPTH(DQ_DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	req_item_t  op_backlog[$];
	deque_rsp_t rsp_expected[$];
	req_item_t  drv_item;
	deque_rsp_t rsp_want;
	int         send_idle = 0;
	int         recv_idle = 0;
	int         mismatch_count = 0;
	int         gen_count = 0;

	word_t  dq_store[DQ_DEPTH];
	pos_t   dq_front = '0;
	count_t dq_held  = '0;

	function automatic pos_t slot_at(int idx);
		return pos_t'(int'(dq_front) + idx);
	endfunction

	function automatic deque_rsp_t deque_apply(func_t f, pos_t p, word_t v);
		deque_rsp_t r;
		word_t      key;
		int         i;
		int         j;
		r.data   = '0;
		r.status = ST_OK;
		case (f)
			FN_PUSH_TAIL: begin
				if (dq_held == DQ_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					dq_store[slot_at(int'(dq_held))] = v;
					dq_held++;
				end
			end
			FN_PUSH_HEAD: begin
				if (dq_held == DQ_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					dq_front = dq_front - 8'd1;
					dq_store[dq_front] = v;
					dq_held++;
				end
			end
			FN_POP_TAIL: begin
				if (dq_held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = dq_store[slot_at(int'(dq_held) - 1)];
					dq_held--;
				end
			end
			FN_POP_HEAD: begin
				if (dq_held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = dq_store[dq_front];
					dq_front = dq_front + 8'd1;
					dq_held--;
				end
			end
			FN_READ: begin
				if (p >= dq_held) r.status = ST_BOUNDS;
				else r.data = dq_store[slot_at(int'(p))];
			end
			FN_WRITE: begin
				if (p >= dq_held) r.status = ST_BOUNDS;
				else dq_store[slot_at(int'(p))] = v;
			end
			FN_SORT: begin
				for (i = 1; i < int'(dq_held); i++) begin
					key = dq_store[slot_at(i)];
					j = i;
					while (j > 0 && dq_store[slot_at(j - 1)] > key) begin
						dq_store[slot_at(j)] = dq_store[slot_at(j - 1)];
						j--;
					end
					dq_store[slot_at(j)] = key;
				end
			end
			default: ;
		endcase
		r.count = dq_held;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			if (drv_valid && req_ch.ready) begin
				rsp_expected.insert(rsp_expected.size(),
					deque_apply(drv_func, drv_position, drv_value));
			end
			if (!drv_valid || req_ch.ready) begin
				if (op_backlog.size() > 0 && $urandom_range(99) >= send_idle) begin
					drv_item = op_backlog[0];
					op_backlog.delete(0);
					drv_valid    <= 1'b1;
					drv_func     <= drv_item.func;
					drv_position <= drv_item.position;
					drv_value    <= drv_item.value;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rcv_ready) begin
				if (rsp_expected.size() == 0) begin
					report_mismatch("unexpected transaction", rsp_ch.data, '0);
				end else begin
					rsp_want = rsp_expected[0];
					rsp_expected.delete(0);
					if (rsp_ch.data !== rsp_want.data)
						report_mismatch("data", rsp_ch.data, rsp_want.data);
					if (rsp_ch.status !== rsp_want.status)
						report_mismatch("status", 32'(rsp_ch.status), 32'(rsp_want.status));
					if (rsp_ch.count !== rsp_want.count)
						report_mismatch("count", 32'(rsp_ch.count), 32'(rsp_want.count));
				end
			end
			rcv_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic queue_op(input func_t f, input pos_t p, input word_t v);
		req_item_t it;
		it.func     = f;
		it.position = p;
		it.value    = v;
		op_backlog.insert(op_backlog.size(), it);
		case (f)
			FN_PUSH_TAIL, FN_PUSH_HEAD: if (gen_count < DQ_DEPTH) gen_count++;
			FN_POP_TAIL, FN_POP_HEAD: if (gen_count > 0) gen_count--;
			default: ;
		endcase
	endtask

	function automatic word_t rand_word();
		int r;
		r = $urandom_range(9);
		case (r)
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			4, 5: return word_t'($urandom_range(15)) - 32'sd8;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic pos_t pick_position();
		if (gen_count > 0 && $urandom_range(9) < 8)
			return pos_t'($urandom_range(gen_count - 1));
		return pos_t'($urandom_range(255));
	endfunction

	task automatic random_op();
		int    r;
		func_t f;
		r = $urandom_range(99);
		if (gen_count > 64) begin
			if (r < 50) f = r[0] ? FN_POP_TAIL : FN_POP_HEAD;
			else if (r < 62) f = r[0] ? FN_PUSH_TAIL : FN_PUSH_HEAD;
			else if (r < 80) f = FN_READ;
			else if (r < 98) f = FN_WRITE;
			else f = FN_SORT;
		end else begin
			if (r < 30) f = r[0] ? FN_PUSH_TAIL : FN_PUSH_HEAD;
			else if (r < 50) f = r[0] ? FN_POP_TAIL : FN_POP_HEAD;
			else if (r < 70) f = FN_READ;
			else if (r < 92) f = FN_WRITE;
			else f = FN_SORT;
		end
		queue_op(f, pick_position(), rand_word());
	endtask

	task automatic wait_drained();
		while (op_backlog.size() != 0 || drv_valid || rsp_expected.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 28;
		recv_idle = 56;
		// empty list corner cases
		queue_op(FN_POP_TAIL, 8'd0, '0);
		queue_op(FN_POP_HEAD, 8'd0, '0);
		queue_op(FN_READ, 8'd0, '0);
		queue_op(FN_WRITE, 8'd0, 32'sd5);
		queue_op(FN_SORT, 8'd0, '0);
		queue_op(FN_NOP, 8'd0, '0);
		queue_op(FN_PUSH_TAIL, 8'hff, 32'sh7fffffff);
		queue_op(FN_SORT, 8'd0, '0);
		queue_op(FN_PUSH_HEAD, 8'd0, 32'sh80000000);
		queue_op(FN_PUSH_TAIL, 8'd0, '0);
		queue_op(FN_PUSH_HEAD, 8'd0, -32'sd1);
		queue_op(FN_READ, 8'd0, '0);
		queue_op(FN_READ, 8'd3, '0);
		queue_op(FN_READ, 8'd4, '0);
		queue_op(FN_READ, 8'hff, '0);
		queue_op(FN_WRITE, 8'd1, 32'sd1);
		queue_op(FN_WRITE, 8'hff, -32'sd1);
		// duplicate value to check sort with equal keys
		queue_op(FN_PUSH_TAIL, 8'd0, -32'sd1);
		queue_op(FN_SORT, 8'd0, '0);
		queue_op(FN_READ, 8'd1, '0);
		queue_op(FN_POP_HEAD, 8'd0, '0);
		queue_op(FN_POP_TAIL, 8'd0, '0);
		queue_op(FN_NOP, 8'hff, -32'sd1);
		repeat (100) random_op();
		wait_drained();

		send_idle = 56;
		recv_idle = 28;
		// fill to full, then full and top position corner cases
		while (gen_count < DQ_DEPTH)
			queue_op($urandom_range(1) ? FN_PUSH_TAIL : FN_PUSH_HEAD,
				pos_t'($urandom_range(255)), rand_word());
		queue_op(FN_PUSH_TAIL, 8'd0, 32'sd3);
		queue_op(FN_PUSH_HEAD, 8'd0, 32'sd4);
		queue_op(FN_READ, 8'd0, '0);
		queue_op(FN_READ, 8'hff, '0);
		queue_op(FN_WRITE, 8'hff, 32'sh80000000);
		queue_op(FN_READ, 8'hff, '0);
		queue_op(FN_SORT, 8'd0, '0);
		queue_op(FN_READ, 8'd0, '0);
		queue_op(FN_READ, 8'hff, '0);
		queue_op(FN_SORT, 8'd0, '0);
		repeat (15) random_op();
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		repeat (120) random_op();
		wait_drained();

		repeat (8) @(posedge clk);
		if (rsp_expected.size() != 0)
			report_mismatch("missing transaction", 32'(rsp_expected.size()), '0);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

### bounded_deque_with_sort.f
hdl/bdq_pkg.sv
hdl/bdq_req_if.sv
hdl/bdq_rsp_if.sv
hdl/bounded_deque_with_sort.sv
dv/bounded_deque_with_sort_tb.sv
